// ===== design/pit_pkg.sv =====
// ----------------------------------------------------------------------------
// Interval timer package
// Shared types, constants and codes for the three-channel interval timer.
// ----------------------------------------------------------------------------
package pit_pkg;

  localparam int CHANNELS_DEF  = 3;
  localparam int TICK_BITS_DEF = 32;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [1:0] PORT_CTRL = 2'd3;

  localparam logic [1:0] ACC_LATCH = 2'd0;
  localparam logic [1:0] ACC_LOW   = 2'd1;
  localparam logic [1:0] ACC_HIGH  = 2'd2;
  localparam logic [1:0] ACC_BOTH  = 2'd3;

  localparam logic [1:0] MODE_ONESHOT = 2'd0;
  localparam logic [1:0] MODE_SQUARE  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCESS,
    ST_MOD_LOAD,
    ST_MOD_RUN,
    ST_UPDATE,
    ST_EMIT
  } pit_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;   // take the request into the datapath
    logic access;    // perform the write or read
    logic mod_load;  // load the remainder unit for the current channel
    logic mod_step;  // one restoring step of the remainder unit
    logic update;    // apply the remainder to the current channel
    logic next_chan; // advance to the next channel
    logic emit;      // load the result register
  } pit_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_tick;
    logic mod_done;
    logic last_chan;
  } pit_stat_t;

endpackage

// ===== design/pit_if.sv =====
// ----------------------------------------------------------------------------
// Valid/ready channel
// Carries one payload word with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface pit_if #(
  parameter int W = 8
) (
  input logic clk
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/interval_timer_three_channel.sv =====
// ----------------------------------------------------------------------------
// Three-channel interval timer
// Byte-port programmable down counters advanced by tick requests.
//
//   channel   dir   payload
//   req       in    cmd, port, data_in, tick_clocks
//   rsp       out   rd_byte, out_levels, rejected
//
// A write or read request goes through the access and emit states before its
// result is registered. A tick request runs the bit-serial remainder unit
// once per channel, reducing tick_clocks modulo each channel's reload.
// Synchronous reset clears all channels; no clearing pass is needed.
// While a result is stalled one more request is taken; it waits in its last
// cycle until the stalled result leaves.
// ----------------------------------------------------------------------------
module interval_timer_three_channel import pit_pkg::*; #(
  parameter int CHANNELS  = CHANNELS_DEF,
  parameter int TICK_BITS = TICK_BITS_DEF
) (
  input logic clk,
  input logic rst,
  pit_if.sink   req,
  pit_if.source rsp
);

  pit_cmd_t  cmd;
  pit_stat_t stat;
  logic      in_ready;
  logic [7:0]          res_read;
  logic [CHANNELS-1:0] res_levels;
  logic                res_rej;
  logic                out_free;

  logic       rsp_valid;
  logic [11:0] rsp_data;

  assign out_free  = !rsp_valid || rsp.ready;
  assign req.ready = in_ready;

  pit_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .out_free (out_free),
    .stat     (stat),
    .cmd      (cmd)
  );

  pit_dp #(.CHANNELS(CHANNELS), .TICK_BITS(TICK_BITS)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_cmd     (req.data[1:0]),
    .in_port    (req.data[3:2]),
    .in_data    (req.data[11:4]),
    .in_clocks  (req.data[12 +: TICK_BITS]),
    .res_read   (res_read),
    .res_levels (res_levels),
    .res_rej    (res_rej)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) rsp_data <= {res_rej, 3'(res_levels), res_read};
  end

  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

endmodule

// ===== design/pit_ctrl.sv =====
// ----------------------------------------------------------------------------
// Interval timer controller
// Sequences one request: access, or a remainder per channel for a tick.
// ----------------------------------------------------------------------------
module pit_ctrl import pit_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      out_free,
  input  pit_stat_t stat,
  output pit_cmd_t  cmd
);

  pit_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (in_valid) state_next = ST_ACCESS;
      ST_ACCESS:   state_next = stat.is_tick ? ST_MOD_LOAD : ST_EMIT;
      ST_MOD_LOAD: state_next = ST_MOD_RUN;
      ST_MOD_RUN:  if (stat.mod_done) state_next = ST_UPDATE;
      ST_UPDATE:   state_next = stat.last_chan ? ST_EMIT : ST_MOD_LOAD;
      ST_EMIT:     if (out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.capture = in_valid;
      end
      ST_ACCESS:   cmd.access = 1'b1;
      ST_MOD_LOAD: cmd.mod_load = 1'b1;
      ST_MOD_RUN:  cmd.mod_step = 1'b1;
      ST_UPDATE: begin
        cmd.update = 1'b1;
        cmd.next_chan = 1'b1;
      end
      ST_EMIT:     cmd.emit = out_free;
      default: ;
    endcase
  end

endmodule

// ===== design/pit_dp.sv =====
// ----------------------------------------------------------------------------
// Interval timer datapath
// Channel registers, byte port logic and a bit-serial remainder unit.
// ----------------------------------------------------------------------------
module pit_dp import pit_pkg::*; #(
  parameter int CHANNELS  = CHANNELS_DEF,
  parameter int TICK_BITS = TICK_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pit_cmd_t             cmd,
  output pit_stat_t            stat,
  input  logic [1:0]           in_cmd,
  input  logic [1:0]           in_port,
  input  logic [7:0]           in_data,
  input  logic [TICK_BITS-1:0] in_clocks,
  output logic [7:0]           res_read,
  output logic [CHANNELS-1:0]  res_levels,
  output logic                 res_rej
);

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int BW = $clog2(TICK_BITS + 1);

  logic [15:0] reload_reg    [CHANNELS];
  logic [15:0] count_value   [CHANNELS];
  logic [15:0] latched_count [CHANNELS];
  logic [1:0]  op_mode       [CHANNELS];
  logic [1:0]  acc_mode      [CHANNELS];
  logic [CHANNELS-1:0] out_level, running, byte_phase;

  logic [1:0]           r_cmd, r_port;
  logic [7:0]           r_data;
  logic [TICK_BITS-1:0] r_clocks;
  logic [7:0]           rd;
  logic                 rej;
  logic [CW-1:0]        chan;

  // Remainder unit: restoring division, one quotient bit per cycle.
  logic [TICK_BITS-1:0] dividend;
  logic [16:0]          rem;
  logic [BW-1:0]        bits_left;
  logic [16:0]          divisor;
  logic [17:0]          trial;

  logic [2:0] wmode;
  logic [1:0] wacc;
  logic [1:0] wch;
  logic       wbad;

  assign wmode = r_data[3:1];
  assign wacc  = r_data[5:4];
  assign wch   = r_data[7:6];
  assign wbad  = r_data[0] || ({30'd0, wch} >= CHANNELS) || (wmode == 3'd1) || (wmode > 3'd3);

  assign divisor = (reload_reg[chan] == 16'd0) ? 17'h10000 : {1'b0, reload_reg[chan]};
  assign trial   = {rem, dividend[TICK_BITS-1]};

  assign stat.is_tick   = (r_cmd == CMD_TICK);
  assign stat.mod_done  = (bits_left == BW'(1));
  assign stat.last_chan = ({30'd0, chan} == CHANNELS - 1);

  // Tick update values for the current channel.
  logic [16:0] r_w, cur, half, steps;
  logic [16:0] wrap_val, dn_val;
  assign r_w      = divisor;
  assign cur      = (count_value[chan] == 16'd0) ? 17'h10000 : {1'b0, count_value[chan]};
  assign half     = r_w >> 1;
  assign steps    = rem;
  assign wrap_val = r_w - (steps - cur);
  assign dn_val   = cur - steps;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      r_cmd    <= in_cmd;
      r_port   <= in_port;
      r_data   <= in_data;
      r_clocks <= in_clocks;
      chan     <= '0;
    end
    if (cmd.mod_load) begin
      dividend  <= r_clocks;
      rem       <= '0;
      bits_left <= BW'(TICK_BITS);
    end
    if (cmd.mod_step) begin
      if ({1'b0, trial} >= {2'b0, divisor}) rem <= 17'(trial - {1'b0, divisor});
      else rem <= trial[16:0];
      dividend  <= dividend << 1;
      bits_left <= bits_left - BW'(1);
    end
    if (cmd.next_chan && !stat.last_chan) chan <= chan + CW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        reload_reg[c]    <= '0;
        count_value[c]   <= '0;
        latched_count[c] <= '0;
        op_mode[c]       <= MODE_ONESHOT;
        acc_mode[c]      <= ACC_LOW;
      end
      out_level  <= '0;
      running    <= '0;
      byte_phase <= '0;
    end else begin
      if (cmd.capture) begin
        rd  <= 8'd0;
        rej <= 1'b0;
      end
      if (cmd.access && r_cmd == CMD_WRITE) begin
        if (r_port == PORT_CTRL) begin
          if (wbad) begin
            rej <= 1'b1;
          end else begin
            acc_mode[CW'(wch)] <= wacc;
            if (wacc == ACC_LATCH) begin
              latched_count[CW'(wch)] <= count_value[CW'(wch)];
            end else begin
              latched_count[CW'(wch)] <= '0;
              op_mode[CW'(wch)]       <= wmode[1:0];
              if (wacc == ACC_BOTH) byte_phase[CW'(wch)] <= 1'b0;
              reload_reg[CW'(wch)]   <= '0;
              count_value[CW'(wch)]  <= '0;
              out_level[CW'(wch)]    <= 1'b1;
              running[CW'(wch)]      <= 1'b0;
            end
          end
        end else if ({30'd0, r_port} < CHANNELS) begin
          logic [CW-1:0] p;
          logic [15:0]   nr;
          logic          go;
          p  = CW'(r_port);
          nr = reload_reg[p];
          go = 1'b0;
          if (acc_mode[p] == ACC_LOW) begin
            nr[7:0] = r_data;
            go = 1'b1;
          end else if (acc_mode[p] == ACC_HIGH) begin
            nr[15:8] = r_data;
            go = 1'b1;
          end else if (!byte_phase[p]) begin
            nr[7:0] = r_data;
            byte_phase[p] <= 1'b1;
          end else begin
            nr[15:8] = r_data;
            byte_phase[p] <= 1'b0;
            go = 1'b1;
          end
          reload_reg[p] <= nr;
          if (go && !running[p]) begin
            count_value[p] <= nr;
            running[p]     <= 1'b1;
            out_level[p]   <= (op_mode[p] != MODE_ONESHOT);
          end
        end
      end
      if (cmd.access && r_cmd == CMD_READ) begin
        if (r_port == PORT_CTRL) begin
          rej <= 1'b1;
        end else if ({30'd0, r_port} < CHANNELS) begin
          logic [CW-1:0] p;
          p = CW'(r_port);
          case (acc_mode[p])
            ACC_LOW:  rd <= count_value[p][7:0];
            ACC_HIGH: rd <= count_value[p][15:8];
            ACC_BOTH: begin
              rd <= byte_phase[p] ? count_value[p][15:8] : count_value[p][7:0];
              byte_phase[p] <= ~byte_phase[p];
            end
            default: begin
              if (!byte_phase[p]) begin
                rd <= latched_count[p][7:0];
                byte_phase[p] <= 1'b1;
              end else begin
                rd <= latched_count[p][15:8];
                byte_phase[p] <= 1'b0;
                latched_count[p] <= '0;
              end
            end
          endcase
        end
      end
      if (cmd.update && running[chan]) begin
        if (cur <= steps) begin
          count_value[chan] <= wrap_val[15:0];
          if (op_mode[chan] == MODE_ONESHOT) begin
            out_level[chan] <= 1'b1;
            running[chan]   <= 1'b0;
          end else if (op_mode[chan] == MODE_SQUARE) begin
            out_level[chan] <= ~out_level[chan];
          end
        end else begin
          if (op_mode[chan] == MODE_SQUARE && cur > half && dn_val <= half)
            out_level[chan] <= ~out_level[chan];
          count_value[chan] <= dn_val[15:0];
        end
      end
    end
  end

  assign res_read   = rd;
  assign res_levels = out_level;
  assign res_rej    = rej;

endmodule

// ===== design/pit_checker.sv =====
// ----------------------------------------------------------------------------
// Interval timer checker
// Port-level properties of the timer, bound to the top level.
// ----------------------------------------------------------------------------
module pit_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [11:0] rsp_data
);

  // Handshake outputs are always driven to known levels out of reset.
  a_known: assert property (@(posedge clk) disable iff (rst)
    !$isunknown({req_ready, rsp_valid})) else $error("handshake unknown");

  // With no older result left, an accepted request is not answered next cycle.
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && (!rsp_valid || rsp_ready)) |=> !rsp_valid)
    else $error("result too early");

  // After an accepted request the block stays busy.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready) else $error("ready after accept");

  // A stalled result holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
    else $error("stalled result changed");

endmodule

bind interval_timer_three_channel pit_checker u_pit_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// Interval timer testbench
// Drives write, read and tick requests into the three-channel interval timer.
// An in-bench timer model predicts each result, and every response is
// checked field by field in arrival order.
// ----------------------------------------------------------------------------
module tb import pit_pkg::*; ();

  localparam int NCH = CHANNELS_DEF;
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  localparam logic [1:0] MODE_RATE = 2'd2;
  localparam int ITEMS = 1700;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic [31:0] tick_clocks;
    logic [7:0]  data_in;
    logic [1:0]  port;
    logic [1:0]  cmd;
  } req_t;

  typedef struct packed {
    logic       rejected;
    logic [2:0] out_levels;
    logic [7:0] rd_byte;
  } rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pit_if #(.W($bits(req_t))) req_ch (.clk(clk));
  pit_if #(.W($bits(rsp_t))) rsp_ch (.clk(clk));

  interval_timer_three_channel dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch.sink),
    .rsp(rsp_ch.source)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Timer state as the block should hold it.
  logic [15:0] reload_q[NCH];
  logic [15:0] count_q[NCH];
  logic [15:0] latch_q[NCH];
  logic [1:0]  mode_q[NCH];
  logic [1:0]  access_q[NCH];
  bit          level_q[NCH];
  bit          run_q[NCH];
  bit          phase_q[NCH];

  rsp_t expected_rsp[$];
  int   mismatches = 0;
  int   sent = 0;
  int   burst_left = 0;
  int   idle_cycles = 0;
  bit   hold_rsp = 1'b0;
  bit   stall_on = 1'b0;

  function automatic longint unsigned span(logic [15:0] v);
    return (v == 16'd0) ? 64'd65536 : {48'd0, v};
  endfunction

  function automatic void timer_reset();
    for (int c = 0; c < NCH; c++) begin
      reload_q[c] = '0; count_q[c] = '0; latch_q[c] = '0;
      mode_q[c] = MODE_ONESHOT; access_q[c] = ACC_LOW;
      level_q[c] = 1'b0; run_q[c] = 1'b0; phase_q[c] = 1'b0;
    end
  endfunction

  function automatic void start_count(int c);
    if (!run_q[c]) begin
      count_q[c] = reload_q[c];
      run_q[c] = 1'b1;
      level_q[c] = (mode_q[c] != MODE_ONESHOT);
    end
  endfunction

  function automatic void advance_count(int c, logic [31:0] clocks);
    longint unsigned r, cur, steps, half;
    r = span(reload_q[c]);
    cur = span(count_q[c]);
    steps = {32'd0, clocks} % r;
    half = r >> 1;
    if (cur <= steps) begin
      count_q[c] = 16'(r - (steps - cur));
      if (mode_q[c] == MODE_ONESHOT) begin
        level_q[c] = 1'b1;
        run_q[c] = 1'b0;
      end else if (mode_q[c] == MODE_SQUARE) begin
        level_q[c] = ~level_q[c];
      end
    end else begin
      if (mode_q[c] == MODE_SQUARE && cur > half && cur - steps <= half)
        level_q[c] = ~level_q[c];
      count_q[c] = 16'(cur - steps);
    end
  endfunction

  function automatic bit control_write(logic [7:0] v);
    int c;
    logic [2:0] m;
    c = v[7:6];
    m = v[3:1];
    if (v[0] || c >= NCH || m == 3'd1 || m > 3'd3) return 1'b1;
    access_q[c] = v[5:4];
    if (v[5:4] == ACC_LATCH) begin
      latch_q[c] = count_q[c];
      return 1'b0;
    end
    latch_q[c] = '0;
    mode_q[c] = m[1:0];
    if (v[5:4] == ACC_BOTH) phase_q[c] = 1'b0;
    reload_q[c] = '0;
    count_q[c] = '0;
    level_q[c] = 1'b1;
    run_q[c] = 1'b0;
    return 1'b0;
  endfunction

  function automatic void reload_write(int c, logic [7:0] b);
    if (access_q[c] == ACC_LOW) begin
      reload_q[c][7:0] = b;
      start_count(c);
    end else if (access_q[c] == ACC_HIGH) begin
      reload_q[c][15:8] = b;
      start_count(c);
    end else if (!phase_q[c]) begin
      reload_q[c][7:0] = b;
      phase_q[c] = 1'b1;
    end else begin
      reload_q[c][15:8] = b;
      phase_q[c] = 1'b0;
      start_count(c);
    end
  endfunction

  function automatic logic [7:0] count_read(int c);
    logic [7:0] r;
    if (access_q[c] == ACC_LOW) return count_q[c][7:0];
    if (access_q[c] == ACC_HIGH) return count_q[c][15:8];
    if (access_q[c] == ACC_BOTH) begin
      r = phase_q[c] ? count_q[c][15:8] : count_q[c][7:0];
      phase_q[c] = ~phase_q[c];
      return r;
    end
    if (!phase_q[c]) begin
      phase_q[c] = 1'b1;
      return latch_q[c][7:0];
    end
    r = latch_q[c][15:8];
    phase_q[c] = 1'b0;
    latch_q[c] = '0;
    return r;
  endfunction

  function automatic rsp_t timer_response(req_t r);
    rsp_t o;
    o = '0;
    if (r.cmd == CMD_WRITE) begin
      if (r.port == PORT_CTRL) o.rejected = control_write(r.data_in);
      else if (r.port < NCH) reload_write(r.port, r.data_in);
    end else if (r.cmd == CMD_READ) begin
      if (r.port == PORT_CTRL) o.rejected = 1'b1;
      else if (r.port < NCH) o.rd_byte = count_read(r.port);
    end else if (r.cmd == CMD_TICK) begin
      for (int c = 0; c < NCH; c++)
        if (run_q[c]) advance_count(c, r.tick_clocks);
    end
    for (int c = 0; c < NCH; c++) o.out_levels[c] = level_q[c];
    return o;
  endfunction

  // Sends one request in bursts with random gaps; predicts on acceptance.
  task automatic send(logic [1:0] cmd, logic [1:0] port, logic [7:0] din,
                      logic [31:0] clocks);
    req_t r;
    int gap;
    r = '{cmd: cmd, port: port, data_in: din, tick_clocks: clocks};
    req_ch.valid <= 1'b1;
    req_ch.data <= r;
    do @(posedge clk); while (!req_ch.ready);
    expected_rsp.push_back(timer_response(r));
    sent++;
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 6);
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  task automatic wr(logic [1:0] port, logic [7:0] b);
    send(CMD_WRITE, port, b, $urandom);
  endtask

  task automatic rd(logic [1:0] port);
    send(CMD_READ, port, 8'($urandom), $urandom);
  endtask

  task automatic tick(logic [31:0] clocks);
    send(CMD_TICK, 2'($urandom), 8'($urandom), clocks);
  endtask

  function automatic logic [7:0] ctrl_word(int c, logic [1:0] acc, logic [1:0] m);
    return {2'(c), acc, 1'b0, m, 1'b0};
  endfunction

  // The request line is dropped first so that no stale request is taken.
  task automatic drain();
    req_ch.valid <= 1'b0;
    wait (expected_rsp.size() == 0);
    @(negedge clk);
  endtask

  task automatic test_reset_state();
    rd(2'd0); rd(2'd1); rd(2'd2);
    rd(PORT_CTRL);
    tick(32'hffff_ffff);
    send(CMD_UNKNOWN, 2'd0, 8'hff, 32'hffff_ffff);
  endtask

  task automatic test_rejects();
    wr(PORT_CTRL, 8'h35);                          // BCD counting
    wr(PORT_CTRL, 8'hf4);                          // channel 3 does not exist
    wr(PORT_CTRL, ctrl_word(0, ACC_BOTH, 2'd1));   // mode 1
    wr(PORT_CTRL, 8'h38);                          // mode 4
    wr(PORT_CTRL, 8'h3e);                          // mode 7
  endtask

  task automatic test_modes();
    wr(PORT_CTRL, ctrl_word(0, ACC_BOTH, MODE_ONESHOT));
    wr(2'd0, 8'h00); wr(2'd0, 8'h00);              // zero reload is 65536
    wr(PORT_CTRL, ctrl_word(1, ACC_LOW, MODE_RATE));
    wr(2'd1, 8'hff);
    wr(PORT_CTRL, ctrl_word(2, ACC_HIGH, MODE_SQUARE));
    wr(2'd2, 8'h01);
    tick(32'd0);
    tick(32'd128);
    wr(PORT_CTRL, ctrl_word(0, ACC_LATCH, MODE_ONESHOT));
    rd(2'd0); rd(2'd0);
    tick(32'hffff_ffff);
    rd(2'd1); rd(2'd2);
    tick(32'h0001_0000);
  endtask

  task automatic random_program();
    int c, n;
    logic [1:0] acc, m;
    logic [15:0] rl;
    c = $urandom_range(0, NCH - 1);
    acc = 2'($urandom_range(1, 3));
    case ($urandom_range(0, 2))
      0: m = MODE_ONESHOT;
      1: m = MODE_RATE;
      default: m = MODE_SQUARE;
    endcase
    case ($urandom_range(0, 3))
      0: rl = 16'($urandom_range(0, 20));
      1: rl = 16'd0;
      default: rl = 16'($urandom);
    endcase
    wr(PORT_CTRL, ctrl_word(c, acc, m));
    if (acc != ACC_HIGH) wr(2'(c), rl[7:0]);
    if (acc != ACC_LOW) wr(2'(c), rl[15:8]);
    n = $urandom_range(2, 10);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0: tick($urandom);
        1: tick(32'($urandom_range(0, 40)));
        2: rd(2'($urandom_range(0, NCH - 1)));
        3: wr(PORT_CTRL, ctrl_word($urandom_range(0, NCH - 1), ACC_LATCH, 2'd0));
        4: wr(2'($urandom_range(0, NCH - 1)), 8'($urandom));
        default: tick(32'($urandom_range(0, 70000)));
      endcase
    end
  endtask

  task automatic test_random();
    while (sent < ITEMS) begin
      if ($urandom_range(0, 9) == 0)
        send(2'($urandom), 2'($urandom), 8'($urandom), $urandom);
      else
        random_program();
    end
  endtask

  task automatic test_backpressure();
    hold_rsp = 1'b1;
    for (int i = 0; i < 6; i++) random_program();
    drain();
    for (int i = 0; i < 4; i++) random_program();
  endtask

  // Receiver: a long hold-off on demand, otherwise stalling in phases.
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_rsp) begin
      rsp_ch.ready <= 1'b0;
      repeat (400) @(negedge clk);
      hold_rsp = 1'b0;
    end else begin
      if ($urandom_range(0, 99) == 0) stall_on = ~stall_on;
      rsp_ch.ready <= stall_on ? ($urandom_range(0, 2) == 0) : 1'b1;
    end
  end

  always @(posedge clk) begin
    rsp_t got, want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got = rsp_ch.data;
      if (expected_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %h", got);
      end else begin
        want = expected_rsp.pop_front();
        if (got.rd_byte !== want.rd_byte || got.out_levels !== want.out_levels ||
            got.rejected !== want.rejected) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: rd_byte %h/%h out_levels %b/%b rejected %b/%b",
                     want.rd_byte, got.rd_byte, want.out_levels, got.out_levels,
                     want.rejected, got.rejected);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      idle_cycles = 0;
    else if (!rst)
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    timer_reset();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_state();
    test_rejects();
    test_modes();
    test_backpressure();
    test_random();
    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
